// ----- src/qbf_pkg.sv -----
`timescale 1ns / 1ps

package qbf_pkg;

    localparam int ROW_W   = 5;
    localparam int SCORE_W = 9;
    localparam int SIZE_W  = 6;
    localparam int GROUP   = 8;
    localparam int GRP_W   = 4;

    // per-cycle control handed to every cell of the chain
    typedef struct packed {
        logic advance;   // pipeline moves this cycle
        logic shift;     // a counted column enters the chain
    } cell_ctrl_t;

endpackage

// ----- src/qbf_cell.sv -----
`timescale 1ns / 1ps

module qbf_cell
    import qbf_pkg::*;
#(
    parameter int DW   = 7,
    parameter int DIST = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic             occupied,
    input  logic [ROW_W-1:0] new_row,
    input  logic [ROW_W-1:0] row_in,
    output logic [ROW_W-1:0] row_out,
    output logic             hit
);

    localparam logic [DW-1:0] DIST_V = DW'(DIST);

    logic [ROW_W-1:0] row_reg;
    logic             hit_reg;
    logic             hit_next;
    logic [ROW_W-1:0] diff;

    // this cell sits DIST columns behind the incoming one
    always_comb
    begin
        diff     = (row_reg >= new_row) ? (row_reg - new_row) : (new_row - row_reg);
        hit_next = ctrl.shift && occupied && (row_reg != new_row) &&
                   ({{(DW-ROW_W){1'b0}}, diff} != DIST_V);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance && ctrl.shift)
        begin
            row_reg <= row_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            hit_reg <= hit_next;
        end
    end

    assign row_out = row_reg;
    assign hit     = hit_reg;

endmodule

// ----- src/qbf_pop.sv -----
`timescale 1ns / 1ps

module qbf_pop
    import qbf_pkg::*;
#(
    parameter int N  = 32,
    parameter int SW = 9
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic [N-1:0]  hits,
    output logic [SW-1:0] total
);

    localparam int G = (N + GROUP - 1) / GROUP;

    logic [GRP_W-1:0] grp_reg  [G];
    logic [GRP_W-1:0] grp_next [G];

    // first level: groups of eight, registered
    always_comb
    begin
        for (int g = 0; g < G; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < N)
                begin
                    grp_next[g] = grp_next[g] + GRP_W'(hits[g * GROUP + j]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < G; g++)
            begin
                grp_reg[g] <= '0;
            end
        end
        else if (advance)
        begin
            for (int g = 0; g < G; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
        end
    end

    // second level: sums the (N + 7) / 8 narrow partial sums, four for N = 32
    always_comb
    begin
        total = '0;
        for (int g = 0; g < G; g++)
        begin
            total = total + SW'(grp_reg[g]);
        end
    end

endmodule

// ----- src/queens_board_fitness.sv -----
`timescale 1ns / 1ps
// Path: a last column passes the stage-one, stage-two and output registers to m_tvalid.
// Throughput: one column per cycle; the cell chain compares a new column against
// every stored column at once, and a two-level registered count tree sums the hits.
// The whole pipeline holds while a result waits on m_tready.
// Reset: rst_n clears counters, flags and pipeline valids; stored rows are not cleared.
module queens_board_fitness
    import qbf_pkg::*;
#(
    parameter int MAX_N = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] queen_row, [7:5] zero
    input  logic        s_tlast,   // last_column
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [8:0] pair_score, [14:9] board_size, [15] solved,
                                   // [16] overflowed, [23:17] zero
);

    localparam int NW_RAW = $clog2(MAX_N + 1);
    localparam int NW     = (NW_RAW > SIZE_W) ? NW_RAW : SIZE_W;
    localparam int SW_RAW = $clog2(MAX_N * (MAX_N - 1) / 2 + 1);
    localparam int SW     = (SW_RAW > SCORE_W) ? SW_RAW : SCORE_W;
    localparam logic [NW-1:0] MAX_V = NW'(MAX_N);

    logic             advance;
    logic             accept;
    logic             counted;
    cell_ctrl_t       ctrl;
    logic [ROW_W-1:0] new_row;
    logic [ROW_W-1:0] chain [MAX_N + 1];
    logic [MAX_N-1:0] hits;
    logic [SW-1:0]    total;

    logic [NW-1:0]    columns_seen_reg, columns_seen_next;
    logic             overflow_flag_reg, overflow_flag_next;
    logic [NW-1:0]    n_item;
    logic             ovf_item;

    logic             p1_valid_reg, p1_last_reg, p1_ovf_reg;
    logic [NW-1:0]    p1_n_reg;
    logic             p2_valid_reg, p2_last_reg, p2_ovf_reg;
    logic [NW-1:0]    p2_n_reg;
    logic [SW-1:0]    p2_full_reg, p2_full_next;
    logic [2*NW-1:0]  prod;

    logic [SW-1:0]    running_score_reg;
    logic [SW-1:0]    score_sum;
    logic             out_valid_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic [SIZE_W-1:0]  out_size_reg;
    logic             out_solved_reg, out_ovf_reg;

    assign advance = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept  = s_tvalid && advance;
    assign counted = columns_seen_reg < MAX_V;
    assign new_row = s_tdata[ROW_W-1:0];

    assign ctrl.advance = advance;
    assign ctrl.shift   = accept && counted;

    always_comb
    begin
        n_item             = counted ? (columns_seen_reg + NW'(1)) : columns_seen_reg;
        ovf_item           = overflow_flag_reg || !counted;
        columns_seen_next  = columns_seen_reg;
        overflow_flag_next = overflow_flag_reg;
        if (accept)
        begin
            columns_seen_next  = s_tlast ? '0 : n_item;
            overflow_flag_next = s_tlast ? 1'b0 : ovf_item;
        end
    end

    assign chain[0] = new_row;

    for (genvar k = 0; k < MAX_N; k++)
    begin : g_cell
        logic occupied;
        assign occupied = NW'(k) < columns_seen_reg;

        qbf_cell #(
            .DW   (NW),
            .DIST (k + 1)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .occupied (occupied),
            .new_row  (new_row),
            .row_in   (chain[k]),
            .row_out  (chain[k + 1]),
            .hit      (hits[k])
        );
    end

    qbf_pop #(
        .N  (MAX_N),
        .SW (SW)
    ) u_pop (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .hits    (hits),
        .total   (total)
    );

    // full score n(n-1)/2 for the board carried with stage one
    always_comb
    begin
        prod         = (p1_n_reg == '0) ? '0 :
                       ({{NW{1'b0}}, p1_n_reg} * {{NW{1'b0}}, p1_n_reg - NW'(1)});
        p2_full_next = SW'(prod >> 1);
        score_sum    = running_score_reg + total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_seen_reg  <= '0;
            overflow_flag_reg <= 1'b0;
            p1_valid_reg      <= 1'b0;
            p2_valid_reg      <= 1'b0;
            running_score_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            columns_seen_reg  <= columns_seen_next;
            overflow_flag_reg <= overflow_flag_next;
            if (advance)
            begin
                p1_valid_reg <= accept;
                p2_valid_reg <= p1_valid_reg;
                out_valid_reg <= 1'b0;
                if (p2_valid_reg)
                begin
                    if (p2_last_reg)
                    begin
                        running_score_reg <= '0;
                        out_valid_reg     <= 1'b1;
                    end
                    else
                    begin
                        running_score_reg <= score_sum;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_last_reg <= s_tlast;
            p1_n_reg    <= n_item;
            p1_ovf_reg  <= ovf_item;
            p2_last_reg <= p1_last_reg;
            p2_n_reg    <= p1_n_reg;
            p2_ovf_reg  <= p1_ovf_reg;
            p2_full_reg <= p2_full_next;
            if (p2_valid_reg && p2_last_reg)
            begin
                out_score_reg  <= score_sum[SCORE_W-1:0];
                out_size_reg   <= p2_n_reg[SIZE_W-1:0];
                out_solved_reg <= (score_sum == p2_full_reg);
                out_ovf_reg    <= p2_ovf_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_ovf_reg, out_solved_reg, out_size_reg, out_score_reg};

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        columns_seen_reg <= MAX_V)
        else $error("column count beyond capacity");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (columns_seen_reg == '0 && !overflow_flag_reg))
        else $error("board state not cleared after last column");

    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while a result is stalled");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && p2_valid_reg && p2_last_reg) |=> m_tvalid)
        else $error("last column produced no result");

    a_ovf_size: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[16]) |-> (m_tdata[14:9] == MAX_V[SIZE_W-1:0]))
        else $error("overflowed board with short size");
`endif

endmodule

// ----- test/queens_board_fitness_tb.sv -----
`timescale 1ns / 1ps

module queens_board_fitness_tb;
    import qbf_pkg::*;

    localparam int QUEENS_MAX   = 32;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 412;

    // declaration order gives m_tdata[16:0] from the top down
    typedef struct packed {
        logic              overflowed;
        logic              solved;
        logic [SIZE_W-1:0] board_size;
        logic [SCORE_W-1:0] pair_score;
    } board_result_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             last;
        logic             typed;
        board_result_t    want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    always #6 clk = ~clk;

    queens_board_fitness #(.MAX_N(QUEENS_MAX)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // directed boards; typed rows carry a result read straight off the rules
    stim_row_t directed_rows [25] = '{
        // single column, both row extremes
        '{5'd0,  1'b1, 1'b1, '{1'b0, 1'b1, 6'd1, 9'd0}},
        '{5'd31, 1'b1, 1'b1, '{1'b0, 1'b1, 6'd1, 9'd0}},
        // two queens on one row
        '{5'd7,  1'b0, 1'b0, '0},
        '{5'd7,  1'b1, 1'b1, '{1'b0, 1'b0, 6'd2, 9'd0}},
        // two queens on a diagonal
        '{5'd0,  1'b0, 1'b0, '0},
        '{5'd1,  1'b1, 1'b1, '{1'b0, 1'b0, 6'd2, 9'd0}},
        // widest row gap
        '{5'd31, 1'b0, 1'b0, '0},
        '{5'd0,  1'b1, 1'b1, '{1'b0, 1'b1, 6'd2, 9'd1}},
        // a 4-queens solution
        '{5'd1,  1'b0, 1'b0, '0},
        '{5'd3,  1'b0, 1'b0, '0},
        '{5'd0,  1'b0, 1'b0, '0},
        '{5'd2,  1'b1, 1'b1, '{1'b0, 1'b1, 6'd4, 9'd6}},
        // all on row 0, then an untyped five-column board
        '{5'd0,  1'b0, 1'b0, '0},
        '{5'd0,  1'b0, 1'b0, '0},
        '{5'd0,  1'b0, 1'b0, '0},
        '{5'd0,  1'b1, 1'b1, '{1'b0, 1'b0, 6'd4, 9'd0}},
        '{5'd10, 1'b0, 1'b0, '0},
        '{5'd21, 1'b0, 1'b0, '0},
        '{5'd5,  1'b0, 1'b0, '0},
        '{5'd16, 1'b0, 1'b0, '0},
        '{5'd27, 1'b1, 1'b0, '0},
        // one long anti-diagonal
        '{5'd31, 1'b0, 1'b0, '0},
        '{5'd30, 1'b0, 1'b0, '0},
        '{5'd29, 1'b0, 1'b0, '0},
        '{5'd28, 1'b1, 1'b1, '{1'b0, 1'b0, 6'd4, 9'd0}}
    };

    int torus_sizes [10] = '{5, 7, 11, 13, 17, 19, 23, 25, 29, 31};
    int phase_idle  [4]  = '{0, 50, 0, 37};
    int phase_stall [4]  = '{0, 0, 50, 37};

    // scoring state of the board in flight
    logic [ROW_W-1:0] kept_rows [QUEENS_MAX];
    int               cols_counted = 0;
    int               pair_tally = 0;
    bit               overflow_seen = 1'b0;

    board_result_t board_queue [$];
    board_result_t seen_result;
    board_result_t next_board;

    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int boards_checked = 0;
    int errors = 0;
    int quiet_cycles = 0;

    function automatic bit score_column(input logic [ROW_W-1:0] row, input logic last,
                                        output board_result_t res);
        int other;
        int gap;
        int full;
        res = '0;
        if (cols_counted < QUEENS_MAX)
        begin
            for (int i = 0; i < cols_counted; i++)
            begin
                other = kept_rows[i];
                gap = (other >= int'(row)) ? other - int'(row) : int'(row) - other;
                if (gap != 0 && gap != cols_counted - i)
                    pair_tally++;
            end
            kept_rows[cols_counted] = row;
            cols_counted++;
        end
        else
        begin
            overflow_seen = 1'b1;
        end
        if (!last)
            return 1'b0;
        full = cols_counted * (cols_counted - 1) / 2;
        res.pair_score = pair_tally[SCORE_W-1:0];
        res.board_size = cols_counted[SIZE_W-1:0];
        res.solved     = (pair_tally == full);
        res.overflowed = overflow_seen;
        cols_counted  = 0;
        pair_tally    = 0;
        overflow_seen = 1'b0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH board %0d %s: got %0d expected %0d", boards_checked, what, got, want);
        errors++;
    endtask

    task automatic send_column(input logic [ROW_W-1:0] row, input logic last,
                               input logic typed, input board_result_t want);
        board_result_t res;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, row};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (score_column(row, last, res))
            board_queue.insert(board_queue.size(), typed ? want : res);
        items_sent++;
    endtask

    // style 0: any rows, 1: rows within the board, 2: modular (toroidal) solution
    task automatic play_board(input int n, input int style);
        int offset;
        logic [ROW_W-1:0] r;
        offset = $urandom_range(n - 1);
        for (int c = 0; c < n; c++)
        begin
            case (style)
                0: r = ROW_W'($urandom_range(31));
                1: r = ROW_W'($urandom_range((n > QUEENS_MAX) ? 31 : n - 1));
                default: r = ROW_W'((2 * c + offset) % n);
            endcase
            send_column(r, c == n - 1, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result = board_result_t'(m_tdata[16:0]);
            if (board_queue.size() == 0)
            begin
                flag_mismatch("unexpected result, pair_score", seen_result.pair_score, -1);
            end
            else
            begin
                next_board = board_queue.pop_front();
                if (seen_result.pair_score != next_board.pair_score)
                    flag_mismatch("pair_score", seen_result.pair_score, next_board.pair_score);
                if (seen_result.board_size != next_board.board_size)
                    flag_mismatch("board_size", seen_result.board_size, next_board.board_size);
                if (seen_result.solved != next_board.solved)
                    flag_mismatch("solved", seen_result.solved, next_board.solved);
                if (seen_result.overflowed != next_board.overflowed)
                    flag_mismatch("overflowed", seen_result.overflowed, next_board.overflowed);
            end
            boards_checked++;
        end
    end

    // counts cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int pick;
        int target;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_column(directed_rows[k].row, directed_rows[k].last,
                        directed_rows[k].typed, directed_rows[k].want);

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    play_board($urandom_range(1, 8), $urandom_range(1));
                else if (pick < 55)
                    play_board($urandom_range(9, QUEENS_MAX), $urandom_range(1));
                else if (pick < 75)
                    play_board(torus_sizes[$urandom_range(9)], 2);
                else if (pick < 85)
                    play_board($urandom_range(4, 8), 1);
                else if (pick < 95)
                    play_board($urandom_range(QUEENS_MAX + 1, QUEENS_MAX + 8), 0);
                else
                    play_board(QUEENS_MAX, 1);
            end
        end
        s_tvalid <= 1'b0;

        while (board_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && board_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- queens_board_fitness.f -----
src/qbf_pkg.sv
src/qbf_cell.sv
src/qbf_pop.sv
src/queens_board_fitness.sv
test/queens_board_fitness_tb.sv
